// File: rtl/tcc_pkg.sv
package tcc_pkg;

    // Default geometry of the character memory
    localparam int COLUMNS_DEF   = 42;
    localparam int ROWS_DEF      = 22;
    localparam int MEM_WORDS_DEF = 8192;

    // Fixed field widths
    localparam int COL_W  = 8;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 13;
    localparam int RAW_W  = 14;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    typedef enum logic {
        ACT_CHAR = 1'b0,
        ACT_END  = 1'b1
    } t_action;

    // One write command toward the character memory
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
        logic              last;
    } t_wr;

endpackage

// File: rtl/tcc_skid.sv
module tcc_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tcc_pkg::t_wr  i_wr,
    output logic          o_valid,
    input  logic          i_ready,
    output tcc_pkg::t_wr  o_wr
);
    import tcc_pkg::*;

    logic r_m_valid;
    logic r_s_valid;
    t_wr  r_main;
    t_wr  r_skid;
    logic in_fire;

    assign o_ready = !r_s_valid;
    assign in_fire = i_valid && !r_s_valid;
    assign o_valid = r_m_valid;
    assign o_wr    = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (!r_m_valid || i_ready) begin
            r_m_valid <= r_s_valid || in_fire;
            r_s_valid <= 1'b0;
        end else if (in_fire) begin
            r_s_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_m_valid || i_ready) begin
            if (r_s_valid) begin
                r_main <= r_skid;
            end else if (in_fire) begin
                r_main <= i_wr;
            end
        end else if (in_fire) begin
            r_skid <= i_wr;
        end
    end

    a_skid_never_full_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> r_m_valid)
        else $error("skid entry held without a main entry");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_valid && i_ready) |=> !r_s_valid && r_m_valid)
        else $error("skid entry not moved forward");

    a_main_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_ready) |=> r_m_valid && $stable(r_main))
        else $error("stalled result changed");

endmodule

// File: rtl/tcc_cursor.sv
module tcc_cursor #(
    parameter int COLUMNS   = tcc_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcc_pkg::ROWS_DEF,
    parameter int MEM_WORDS = tcc_pkg::MEM_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_action,
    input  logic [tcc_pkg::CHAR_W-1:0]  i_char_code,
    output logic                        o_wr_valid,
    input  logic                        i_wr_ready,
    output tcc_pkg::t_wr                o_wr
);
    import tcc_pkg::*;

    localparam logic [19:0] M1 = 20'(MEM_WORDS);
    localparam logic [19:0] M2 = 20'(2 * MEM_WORDS);
    localparam logic [19:0] M4 = 20'(4 * MEM_WORDS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [COL_W:0]   COLS_9   = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // Reduce an address below eight memory sizes into the memory
    function automatic logic [ADDR_W-1:0] mem_wrap(input logic [RAW_W-1:0] a);
        logic [19:0] v;
        v = 20'(a);
        if (v >= M4) v = v - M4;
        if (v >= M2) v = v - M2;
        if (v >= M1) v = v - M1;
        return v[ADDR_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
        return (r == LAST_ROW) ? '0 : r + ROW_W'(1);
    endfunction

    // Input register
    logic               r_in_valid;
    logic               r_in_action;
    logic [CHAR_W-1:0]  r_in_code;

    // Cursor state
    logic [COL_W-1:0]   r_col;
    logic [COL_W-1:0]   r_rem;       // column modulo COLUMNS
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_nl_row;    // row a newline moves to
    logic [ADDR_W-1:0]  r_row_base;
    logic               r_pending;

    // Line-clear burst
    logic               r_burst;
    logic [COL_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]  r_clr_base;

    logic               is_nl;
    logic               is_char;
    logic               consume;
    logic [COL_W:0]     rem_inc;
    logic [ROW_W-1:0]   clr_row;

    assign is_nl   = (r_in_action == ACT_CHAR) ? (r_in_code == NEWLINE_CODE) : r_pending;
    assign is_char = (r_in_action == ACT_CHAR) && (r_in_code != NEWLINE_CODE);
    assign consume = r_in_valid && !r_burst && (!is_char || i_wr_ready);
    assign o_ready = !r_in_valid || consume;
    assign rem_inc = {1'b0, r_rem} + (COL_W + 1)'(1);
    assign clr_row = row_inc(r_nl_row);

    always_comb begin
        o_wr_valid = 1'b0;
        o_wr.data  = '0;
        o_wr.last  = 1'b1;
        o_wr.addr  = mem_wrap(RAW_W'(r_row_base) + RAW_W'(r_col));
        if (r_burst) begin
            o_wr_valid = 1'b1;
            o_wr.last  = (r_cnt == LAST_COL);
            o_wr.addr  = mem_wrap(RAW_W'(r_clr_base) + RAW_W'(r_cnt));
        end else if (r_in_valid && is_char) begin
            o_wr_valid = 1'b1;
            o_wr.data  = r_in_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_action <= i_action;
            r_in_code   <= i_char_code;
        end
        if (!r_burst && consume && is_nl) begin
            r_clr_base <= ADDR_W'(32'(clr_row) * COLUMNS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_col      <= '0;
            r_rem      <= '0;
            r_row      <= '0;
            r_nl_row   <= row_inc('0);
            r_row_base <= '0;
            r_pending  <= 1'b1;
            r_burst    <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_in_valid <= (o_ready && i_valid) || (r_in_valid && !consume);
            if (r_burst) begin
                if (i_wr_ready) begin
                    r_cnt <= r_cnt + COL_W'(1);
                    if (r_cnt == LAST_COL) begin
                        r_burst <= 1'b0;
                    end
                end
            end else if (consume) begin
                if (is_char) begin
                    r_col     <= r_col + COL_W'(1);
                    r_pending <= 1'b1;
                    if (r_col == '1) begin
                        r_rem    <= '0;
                        r_nl_row <= row_inc(r_row);
                    end else if (rem_inc == COLS_9) begin
                        r_rem    <= '0;
                        r_nl_row <= row_inc(r_nl_row);
                    end else begin
                        r_rem <= rem_inc[COL_W-1:0];
                    end
                end else if (is_nl) begin
                    r_row      <= r_nl_row;
                    r_nl_row   <= clr_row;
                    r_row_base <= ADDR_W'(32'(r_nl_row) * COLUMNS);
                    r_col      <= '0;
                    r_rem      <= '0;
                    r_burst    <= 1'b1;
                    r_cnt      <= '0;
                    r_pending  <= r_in_action;
                end else begin
                    r_pending <= 1'b1;
                end
            end
        end
    end

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= LAST_ROW) && (r_nl_row <= LAST_ROW))
        else $error("cursor row out of range");

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= LAST_COL)
        else $error("column remainder out of range");

    a_burst_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_burst && i_wr_ready && o_wr.last) |=> !r_burst)
        else $error("line clear did not end after its last write");

    a_no_take_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst |-> !consume)
        else $error("item consumed during line clear");

endmodule

// File: rtl/text_console_cursor_writer.sv
// Channel   Dir  Fields (tdata / tuser / tlast)
// s_axis    in   tdata[7:0] char_code, tuser action (0 char, 1 end of string)
// m_axis    out  tdata[12:0] write_addr, tdata[20:13] write_data, tlast last_write
//
// An ordinary byte gives one write and the block takes one byte per cycle
// while m_axis is not stalled. A newline, or an end marker that closes a
// string, first moves the cursor, then the clear counter issues COLUMNS
// writes. i_rst_n is synchronous, active low; it homes the cursor and sets
// the pending-newline flag. A stalled m_axis holds its transfer; a two-entry
// skid buffer keeps s_axis taking bytes while one result waits.
module text_console_cursor_writer #(
    parameter int COLUMNS   = tcc_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcc_pkg::ROWS_DEF,
    parameter int MEM_WORDS = tcc_pkg::MEM_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [12:0] write_addr, [20:13] write_data, [23:21] zero
    output logic        m_axis_tlast
);
    import tcc_pkg::*;

    logic wr_valid;
    logic wr_ready;
    t_wr  wr_cmd;
    t_wr  out_cmd;

    // Cursor tracking and line-clear sequencing
    tcc_cursor #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .MEM_WORDS (MEM_WORDS)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_char_code (s_axis_tdata),
        .o_wr_valid  (wr_valid),
        .i_wr_ready  (wr_ready),
        .o_wr        (wr_cmd)
    );

    // Result register with skid entry
    tcc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (wr_valid),
        .o_ready (wr_ready),
        .i_wr    (wr_cmd),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_wr    (out_cmd)
    );

    // Pack the write command: address low, data above, zero fill
    assign m_axis_tdata = {3'b000, out_cmd.data, out_cmd.addr};
    assign m_axis_tlast = out_cmd.last;

endmodule

// File: test/text_console_cursor_writer_tb.sv
`timescale 1ns / 100ps

module text_console_cursor_writer_tb;
    import tcc_pkg::*;

    localparam int COLUMNS     = COLUMNS_DEF;
    localparam int ROWS        = ROWS_DEF;
    localparam int MEM_WORDS   = MEM_WORDS_DEF;
    // Far above the slowest legal run: every item a newline, every write stalled
    localparam int CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 3 * COLUMNS;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] char_code
    logic        s_axis_tuser  = 1'b0; // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [12:0] write_addr, [20:13] write_data, [23:21] zero
    logic        m_axis_tlast;

    // Cursor state of the predictor
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic             newline_due;

    t_wr queued_writes[$];  // predicted writes, oldest first
    int  error_count   = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;

    text_console_cursor_writer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("text_console_cursor_writer_tb: FAIL");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic void push_write(int addr, logic [CHAR_W-1:0] data, logic last);
        t_wr w;
        w.addr = ADDR_W'(addr % MEM_WORDS);
        w.data = data;
        w.last = last;
        queued_writes.push_back(w);
    endfunction

    // Move the cursor down, home the column, then clear the row below
    function automatic void model_newline();
        int new_row;
        int clr_row;
        new_row    = (int'(cursor_row) + 1 + int'(cursor_col) / COLUMNS) % ROWS;
        cursor_row = ROW_W'(new_row);
        cursor_col = '0;
        clr_row    = (new_row + 1) % ROWS;
        for (int c = 0; c < COLUMNS; c++)
            push_write(clr_row * COLUMNS + c, '0, (c == COLUMNS - 1));
    endfunction

    // Queue the writes that one accepted byte or end marker causes
    function automatic void model_text_item(t_action act, logic [CHAR_W-1:0] code);
        if (act == ACT_END) begin
            if (newline_due)
                model_newline();
            newline_due = 1'b1;
        end else if (code == NEWLINE_CODE) begin
            model_newline();
            newline_due = 1'b0;
        end else begin
            push_write(int'(cursor_row) * COLUMNS + int'(cursor_col), code, 1'b1);
            cursor_col  = cursor_col + 1'b1;  // wraps at 256, never at line end
            newline_due = 1'b1;
        end
    endfunction

    // Sink side: stall at random; a percentage of 0 keeps tready high
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare every write transfer against the oldest predicted write
    always @(posedge i_clk) begin : check_writes
        t_wr want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (queued_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write tdata=%h tlast=%b",
                                          m_axis_tdata, m_axis_tlast));
            end else begin
                want = queued_writes.pop_front();
                if (m_axis_tdata[ADDR_W-1:0] !== want.addr)
                    report_mismatch($sformatf("write_addr got %0d want %0d",
                                              m_axis_tdata[ADDR_W-1:0], want.addr));
                if (m_axis_tdata[ADDR_W+CHAR_W-1:ADDR_W] !== want.data)
                    report_mismatch($sformatf("write_data got %0d want %0d",
                                              m_axis_tdata[ADDR_W+CHAR_W-1:ADDR_W],
                                              want.data));
                if (m_axis_tdata[23:ADDR_W+CHAR_W] !== '0)
                    report_mismatch($sformatf("tdata pad bits got %b",
                                              m_axis_tdata[23:ADDR_W+CHAR_W]));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last_write got %b want %b",
                                              m_axis_tlast, want.last));
            end
        end
    end

    // Offer one item, hold it until the transfer, then predict its writes.
    // Valid stays high on return so a back-to-back item needs no second
    // assignment in the same step; lower it only when idling.
    task automatic send_item(t_action act, logic [CHAR_W-1:0] code);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        model_text_item(act, code);
    endtask

    // Drop valid and hold off until every predicted write has come out;
    // always advance past a clock edge so the next drive lands in a new step
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (queued_writes.size() != 0);
    endtask

    // End marker straight after reset: the string is empty, so it must newline
    task automatic test_empty_string();
        send_item(ACT_END, 8'hFF);
    endtask

    // Byte zero and the byte extremes are plain characters
    task automatic test_byte_extremes();
        send_item(ACT_CHAR, 8'h00);
        send_item(ACT_CHAR, 8'hFF);
        send_item(ACT_CHAR, 8'hAA);
        send_item(ACT_CHAR, 8'h55);
        send_item(ACT_CHAR, 8'h01);
        send_item(ACT_CHAR, 8'h80);
        send_item(ACT_CHAR, 8'h7F);
        send_item(ACT_CHAR, 8'h0B);
        send_item(ACT_END, 8'h00);
    endtask

    // End marker after a newline gives nothing; a second end marker newlines
    task automatic test_end_marker_cases();
        send_item(ACT_CHAR, 8'h41);
        send_item(ACT_CHAR, NEWLINE_CODE);
        send_item(ACT_END, 8'h5A);
        send_item(ACT_END, 8'hA5);
        send_item(ACT_CHAR, NEWLINE_CODE);
        send_item(ACT_CHAR, NEWLINE_CODE);
        send_item(ACT_END, NEWLINE_CODE);
        send_item(ACT_CHAR, 8'h42);
        send_item(ACT_END, 8'h0F);
        send_item(ACT_END, 8'hF0);
    endtask

    // One long line with no newline: the column rolls over from 255 to 0,
    // then the end marker closes the string from the wrapped column
    task automatic test_column_wrap();
        logic [CHAR_W-1:0] code;
        repeat (257) begin
            code = 8'($urandom_range(0, 255));
            if (code == NEWLINE_CODE)
                code = 8'h20;
            send_item(ACT_CHAR, code);
        end
        send_item(ACT_END, 8'($urandom_range(0, 255)));
    endtask

    // Mostly short strings closed by an end marker, a few long lines,
    // newlines scattered inside and often at the very end
    task automatic test_random_strings(int n_items, int send_pct, int recv_pct);
        int               sent;
        int               len;
        logic [CHAR_W-1:0] code;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 80)
                len = $urandom_range(0, 6);
            else
                len = $urandom_range(20, 90);
            // Keep the string and its end marker inside the item budget
            if (len > n_items - sent - 1)
                len = n_items - sent - 1;
            for (int i = 0; i < len; i++) begin
                code = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < 12)
                    code = NEWLINE_CODE;
                if (i == len - 1 && $urandom_range(0, 99) < 30)
                    code = NEWLINE_CODE;
                send_item(ACT_CHAR, code);
                sent++;
            end
            send_item(ACT_END, 8'($urandom_range(0, 255)));
            sent++;
            if ($urandom_range(0, 99) < 5)
                wait_drained();
        end
    endtask

    initial begin
        cursor_col  = '0;
        cursor_row  = '0;
        newline_due = 1'b1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_empty_string();
        test_byte_extremes();
        test_end_marker_cases();
        wait_drained();

        test_random_strings(12, 20, 87);
        wait_drained();
        test_random_strings(12, 87, 20);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_column_wrap();

        // Let late or extra writes show up before the verdict
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("text_console_cursor_writer_tb: PASS");
        else
            $display("text_console_cursor_writer_tb: FAIL");
        $finish;
    end

endmodule

// File: text_console_cursor_writer.f
rtl/tcc_pkg.sv
rtl/tcc_skid.sv
rtl/tcc_cursor.sv
rtl/text_console_cursor_writer.sv
test/text_console_cursor_writer_tb.sv
